// ----- rtl/zfpm_pkg.sv -----
// ----------------------------------------------------------------------------
// zfpm_pkg
// Shared sizes, controller commands and status for the Z-function matcher.
// ----------------------------------------------------------------------------
package zfpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 6;
    localparam int POS_W       = 32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Request kinds
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;    // store a pattern byte
        logic search;  // process a text byte
        logic zinit;   // seed k for the current Z index
        logic zext;    // one extension compare
        logic div;     // one divisibility subtract step
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic i_end;     // all Z indexes done
        logic ext_more;  // extension continues
        logic div_more;  // remainder still at least the period
    } t_status;

endpackage

// ----- rtl/zfpm_if.sv -----
// ----------------------------------------------------------------------------
// zfpm_req_if / zfpm_rsp_if
// Valid/ready channels for request bytes and per-byte results.
// ----------------------------------------------------------------------------
interface zfpm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, req_type, char_in, is_last, input ready);
    modport sink   (input valid, req_type, char_in, is_last, output ready);
endinterface

interface zfpm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       match_found;
    logic [31:0]                match_start;
    logic                       pattern_done;
    logic [zfpm_pkg::LEN_W-1:0] border_length;
    logic [zfpm_pkg::LEN_W-1:0] full_period;
    logic                       pattern_overflow;

    modport source (output valid, match_found, match_start, pattern_done, border_length,
                    full_period, pattern_overflow, input ready);
    modport sink   (input valid, match_found, match_start, pattern_done, border_length,
                    full_period, pattern_overflow, output ready);
endinterface

// ----- rtl/z_function_pattern_matcher.sv -----
// Pattern bytes and text bytes give their registered result in the cycle after acceptance.
// The last pattern byte runs the Z build: per index a seed step, then one step per extension
// compare until one fails; then the period check runs its subtract steps. The result follows
// in the cycle after the last period-check step.
// One byte per cycle while streaming and results are taken; input stalls until the period check ends.
// Reset: synchronous active-low i_rst_n clears all control state; no pattern matches.
// ----------------------------------------------------------------------------
// z_function_pattern_matcher
// Z-algorithm pattern analysis and streaming text match, top level.
// ----------------------------------------------------------------------------
module z_function_pattern_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zfpm_req_if.sink    i_req,
    zfpm_rsp_if.source  o_rsp
);

    zfpm_pkg::t_cmd    cmd;
    zfpm_pkg::t_status status;
    logic              idle, done, accept;
    logic              r_out_valid;

    // Accept only while idle and the result slot is free or draining
    assign i_req.ready = idle && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    zfpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req.req_type),
        .i_is_last  (i_req.is_last),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_done     (done)
    );

    zfpm_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_char    (i_req.char_in),
        .i_is_last (i_req.is_last),
        .o_status  (status),
        .o_found   (o_rsp.match_found),
        .o_start   (o_rsp.match_start),
        .o_ready   (o_rsp.pattern_done),
        .o_border  (o_rsp.border_length),
        .o_period  (o_rsp.full_period),
        .o_ovf     (o_rsp.pattern_overflow)
    );

    // Result valid: set by a finished transaction, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done || cmd.search || (cmd.load && !i_req.is_last)) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_out_valid;

endmodule

// ----- rtl/zfpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// zfpm_ctrl
// Sequencer: idle/stream handling, Z-array build loop, period check.
// ----------------------------------------------------------------------------
module zfpm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_req_type,
    input  logic               i_is_last,
    input  zfpm_pkg::t_status  i_status,
    output zfpm_pkg::t_cmd     o_cmd,
    output logic               o_idle,
    output logic               o_done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ZINIT = 2'd1;
    localparam logic [1:0] S_ZEXT  = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    logic [1:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load   = i_accept && (i_req_type == zfpm_pkg::REQ_PATTERN);
                o_cmd.search = i_accept && (i_req_type == zfpm_pkg::REQ_TEXT);
                if (o_cmd.load && i_is_last) n_state = S_ZINIT;
            end
            S_ZINIT: begin
                if (i_status.i_end) begin
                    n_state = S_DIV;
                end else begin
                    o_cmd.zinit = 1'b1;
                    n_state     = S_ZEXT;
                end
            end
            S_ZEXT: begin
                o_cmd.zext = 1'b1;
                if (!i_status.ext_more) n_state = S_ZINIT;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (!i_status.div_more) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ----- rtl/zfpm_dp.sv -----
// ----------------------------------------------------------------------------
// zfpm_dp
// Pattern store, Z array, prefix-match vector for text, result registers.
// ----------------------------------------------------------------------------
module zfpm_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  zfpm_pkg::t_cmd              i_cmd,
    input  logic [7:0]                  i_char,
    input  logic                        i_is_last,
    output zfpm_pkg::t_status           o_status,
    output logic                        o_found,
    output logic [zfpm_pkg::POS_W-1:0]  o_start,
    output logic                        o_ready,
    output logic [zfpm_pkg::LEN_W-1:0]  o_border,
    output logic [zfpm_pkg::LEN_W-1:0]  o_period,
    output logic                        o_ovf
);

    localparam int MAXP = zfpm_pkg::MAX_PATTERN;
    localparam int IW   = zfpm_pkg::IDX_W;
    localparam int LW   = zfpm_pkg::LEN_W;
    localparam int PW   = zfpm_pkg::POS_W;

    logic [7:0]    r_pat [MAXP];
    logic [LW-1:0] r_z   [MAXP];
    logic [LW-1:0] r_len;
    logic [PW-1:0] r_pos;
    logic          r_ready, r_open, r_ovf, r_fb;
    logic [LW-1:0] r_border, r_period;
    logic [MAXP-1:0] r_d;
    logic [LW-1:0] r_i, r_lo, r_hi, r_k, r_p, r_rem;
    logic          r_found;
    logic [PW-1:0] r_start;

    logic [LW-1:0]   len_eff, len_new, ik, zprev, k0, hi_gap;
    logic [MAXP-1:0] d_new;
    logic [PW-1:0]   pos_new;

    // Loading length after an optional restart
    assign len_eff = r_open ? r_len : '0;
    assign len_new = (len_eff < LW'(MAXP)) ? len_eff + 1'b1 : len_eff;

    // Z-box seed
    assign ik     = r_i + r_k;
    assign zprev  = r_z[IW'(r_i - r_lo)];
    assign hi_gap = r_hi - r_i;
    assign k0     = (r_i < r_hi) ? ((zprev > hi_gap) ? hi_gap : zprev) : '0;

    assign o_status.i_end    = (r_i >= r_len);
    assign o_status.ext_more = (ik < r_len) && (r_pat[IW'(r_k)] == r_pat[IW'(ik)]);
    assign o_status.div_more = (r_rem >= r_p);

    // Shift-and prefix match on text bytes
    always_comb begin
        for (int j = 0; j < MAXP; j++) begin
            d_new[j] = ((j == 0) ? 1'b1 : r_d[(j == 0) ? 0 : j-1]) && (i_char == r_pat[j]);
        end
    end
    assign pos_new = (r_pos == zfpm_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;

    // Pattern and Z storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (len_eff < LW'(MAXP))) r_pat[IW'(len_eff)] <= i_char;
        if (i_cmd.load && i_is_last) r_z[0] <= len_new;
        if (i_cmd.zext && !o_status.ext_more) r_z[IW'(r_i)] <= r_k;
    end

    // Control and result state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_pos <= '0; r_ready <= 1'b0; r_open <= 1'b0;
            r_ovf <= 1'b0; r_border <= '0; r_period <= '0; r_d <= '0;
            r_found <= 1'b0; r_start <= '0; r_fb <= 1'b0;
            r_i <= '0; r_lo <= '0; r_hi <= '0; r_k <= '0; r_p <= '0; r_rem <= '0;
        end else begin
            if (i_cmd.load) begin
                r_found  <= 1'b0;
                r_start  <= '0;
                r_len    <= len_new;
                r_ovf    <= (r_open && r_ovf) || (len_eff == LW'(MAXP));
                r_ready  <= 1'b0;
                r_border <= '0;
                r_period <= '0;
                r_open   <= !i_is_last;
                if (i_is_last) begin
                    r_pos  <= '0;
                    r_d    <= '0;
                    r_i    <= LW'(1);
                    r_lo   <= '0;
                    r_hi   <= '0;
                    r_fb   <= 1'b0;
                    r_p    <= len_new;
                    r_rem  <= len_new;
                    r_period <= len_new;
                end
            end
            if (i_cmd.search) begin
                r_found <= r_ready && d_new[IW'(r_len - 1'b1)];
                r_start <= !(r_ready && d_new[IW'(r_len - 1'b1)]) ? '0 :
                           (pos_new == zfpm_pkg::POS_MAX) ? zfpm_pkg::POS_MAX :
                           pos_new - PW'(r_len) + 1'b1;
                r_pos   <= i_is_last ? '0 : pos_new;
                r_d     <= i_is_last ? '0 : d_new;
            end
            if (i_cmd.zinit) r_k <= k0;
            if (i_cmd.zext) begin
                if (o_status.ext_more) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    if (ik > r_hi) begin
                        r_lo <= r_i;
                        r_hi <= ik;
                    end
                    // first border hit gives the smallest period
                    if (!r_fb && (ik == r_len)) begin
                        r_fb     <= 1'b1;
                        r_border <= r_k;
                        r_p      <= r_i;
                    end
                    r_i <= r_i + 1'b1;
                end
            end
            if (i_cmd.div) begin
                if (o_status.div_more) begin
                    r_rem <= r_rem - r_p;
                end else begin
                    r_period <= (r_rem == '0) ? r_p : r_len;
                    r_ready  <= 1'b1;
                end
            end
        end
    end

    assign o_found  = r_found;
    assign o_start  = r_start;
    assign o_ready  = r_ready;
    assign o_border = r_border;
    assign o_period = r_period;
    assign o_ovf    = r_ovf;

endmodule
